// File: rtl/dngr_pkg.sv
// Shared constants and the digit font table for the decimal glyph renderer.
`timescale 1ns / 1ps
package dngr_pkg;

    localparam int DEF_NUM_DIGITS    = 5;
    localparam int DEF_GLYPH_COLUMNS = 5;

    localparam int          FONT_COLS   = 5;
    localparam logic [7:0]  DIGIT_PITCH = 8'd6;

    // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 16-bit v
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // 5x8 font: one byte per column, bit j lights row j
    function automatic logic [7:0] font_column(input logic [3:0] digit, input logic [2:0] col);
        logic [39:0] glyph;
        logic [7:0]  bits;
        glyph = 40'h0;
        bits  = 8'h00;
        case (digit)
            4'd0:    glyph = 40'h7E_81_81_81_7E;
            4'd1:    glyph = 40'h80_82_FF_80_80;
            4'd2:    glyph = 40'hC2_A1_91_89_86;
            4'd3:    glyph = 40'h42_81_89_89_76;
            4'd4:    glyph = 40'h10_18_14_12_FF;
            4'd5:    glyph = 40'h4F_89_89_89_71;
            4'd6:    glyph = 40'h7C_92_91_91_60;
            4'd7:    glyph = 40'h01_01_F9_05_03;
            4'd8:    glyph = 40'h76_89_89_89_76;
            4'd9:    glyph = 40'h06_89_89_49_3E;
            default: glyph = 40'h0;
        endcase
        case (col)
            3'd0:    bits = glyph[39:32];
            3'd1:    bits = glyph[31:24];
            3'd2:    bits = glyph[23:16];
            3'd3:    bits = glyph[15:8];
            3'd4:    bits = glyph[7:0];
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

endpackage

// File: rtl/decimal_number_glyph_renderer_unit.sv
// Top level: value to decimal digits, then font column writes per digit.
//
// Usage: an input item (i_value, i_start_x, i_start_y) is taken on the
// i_valid/o_ready handshake. The value is split into NUM_DIGITS decimal
// digits, one digit per cycle, each stored in a small digit memory with
// a registered read. Leading zeros are dropped; each remaining
// digit is read back, most significant first, and sent as GLYPH_COLUMNS
// column items on o_valid/i_ready (o_column_x, o_column_y,
// o_column_bits, o_last). o_last marks the final column of the item.
// A value of zero gives no output items.
// The digit loop does one divide-by-ten step per cycle; the column
// sequencer passes through a memory read state (S_FETCH) for each digit
// before its columns. The first column follows the conversion and a fetch.
// Output is a register: a stalled receiver holds the current column and
// freezes the sequencer; a new input item is taken as soon as the
// sequencer is idle, even while the last column still waits.
// Reset (synchronous, active low) returns to idle with no output pending.
`timescale 1ns / 1ps
module decimal_number_glyph_renderer_unit
    import dngr_pkg::*;
#(
    parameter int NUM_DIGITS    = DEF_NUM_DIGITS,
    parameter int GLYPH_COLUMNS = DEF_GLYPH_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_start_x,
    input  logic [7:0]  i_start_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_column_x,
    output logic [7:0]  o_column_y,
    output logic [7:0]  o_column_bits,
    output logic        o_last
);

    localparam int KW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CW = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(NUM_DIGITS - 1);
    localparam logic [CW-1:0] C_LAST = CW'(GLYPH_COLUMNS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [15:0]   r_v, n_v;
    logic [7:0]    r_dx, n_dx;
    logic [7:0]    r_sy, n_sy;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_top, n_top;
    logic          r_any, n_any;
    logic [CW-1:0] r_col, n_col;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_x, n_out_x;
    logic [7:0]    r_out_y, n_out_y;
    logic [7:0]    r_out_bits, n_out_bits;
    logic          r_out_last, n_out_last;

    logic [3:0]    r_dig_mem [NUM_DIGITS];
    logic [3:0]    r_rd_digit;

    logic [31:0]   w_prod;
    logic [12:0]   w_quot;
    logic [15:0]   w_quot10;
    logic [3:0]    w_rem;
    logic          w_wr_en;
    logic          w_slot_free;

    assign w_prod   = 32'(r_v) * 32'(RECIP_10);
    assign w_quot   = w_prod[31:RECIP_SHIFT];
    assign w_quot10 = {w_quot[12:0], 3'b000} + {2'b00, w_quot[12:0], 1'b0};
    assign w_rem    = 4'(r_v - w_quot10);
    assign w_wr_en  = (r_state == S_CONV);

    assign w_slot_free = !r_out_valid || i_ready;

    // digit memory: write during conversion, registered read at r_k
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_dig_mem[r_k] <= w_rem;
        end
        r_rd_digit <= r_dig_mem[r_k];
    end

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_dx        = r_dx;
        n_sy        = r_sy;
        n_k         = r_k;
        n_top       = r_top;
        n_any       = r_any;
        n_col       = r_col;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_bits  = r_out_bits;
        n_out_last  = r_out_last;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_v     = i_value;
                    n_dx    = i_start_x;
                    n_sy    = i_start_y;
                    n_k     = '0;
                    n_top   = '0;
                    n_any   = 1'b0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_v = {3'b000, w_quot};
                if (w_rem != 4'd0) begin
                    n_top = r_k;
                    n_any = 1'b1;
                end
                if (r_k == K_LAST) begin
                    // start from the top nonzero digit, or drop an all-zero value
                    n_k     = (w_rem != 4'd0) ? r_k : r_top;
                    n_col   = '0;
                    n_state = (r_any || w_rem != 4'd0) ? S_FETCH : S_IDLE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_dx + 8'(r_col);
                    n_out_y     = r_sy;
                    n_out_bits  = font_column(r_rd_digit, 3'(r_col));
                    n_out_last  = (r_col == C_LAST) && (r_k == '0);
                    if (r_col == C_LAST) begin
                        n_col = '0;
                        n_dx  = r_dx + DIGIT_PITCH;
                        if (r_k == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_k     = r_k - KW'(1);
                            n_state = S_FETCH;
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_top       <= '0;
            r_any       <= 1'b0;
            r_col       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_top       <= n_top;
            r_any       <= n_any;
            r_col       <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_dx       <= n_dx;
        r_sy       <= n_sy;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_bits <= n_out_bits;
        r_out_last <= n_out_last;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_column_x    = r_out_x;
    assign o_column_y    = r_out_y;
    assign o_column_bits = r_out_bits;
    assign o_last        = r_out_last;

endmodule

// File: test/decimal_number_glyph_renderer_unit_tb.sv
// Self-checking testbench for the decimal number glyph renderer.
`timescale 1ns / 1ps
module decimal_number_glyph_renderer_unit_tb
    import dngr_pkg::*;
();

    localparam int N_DIGITS    = DEF_NUM_DIGITS;
    localparam int N_COLUMNS   = DEF_GLYPH_COLUMNS;
    localparam int X_STEP      = 6;
    localparam int RANDOM_NUMS = 260;
    localparam int DRAIN_WAIT  = 48;
    localparam int CYCLE_LIMIT = 400000;

    // digit glyphs, five columns each, bit j lights row j
    localparam logic [0:9][0:4][7:0] DIGIT_FONT = {
        8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E,
        8'h80, 8'h82, 8'hFF, 8'h80, 8'h80,
        8'hC2, 8'hA1, 8'h91, 8'h89, 8'h86,
        8'h42, 8'h81, 8'h89, 8'h89, 8'h76,
        8'h10, 8'h18, 8'h14, 8'h12, 8'hFF,
        8'h4F, 8'h89, 8'h89, 8'h89, 8'h71,
        8'h7C, 8'h92, 8'h91, 8'h91, 8'h60,
        8'h01, 8'h01, 8'hF9, 8'h05, 8'h03,
        8'h76, 8'h89, 8'h89, 8'h89, 8'h76,
        8'h06, 8'h89, 8'h89, 8'h49, 8'h3E
    };

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [1:0]  phase;
    } number_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] bits;
        logic       last;
    } column_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_value = '0;
    logic [7:0]  i_start_x = '0;
    logic [7:0]  i_start_y = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_column_x;
    logic [7:0]  o_column_y;
    logic [7:0]  o_column_bits;
    logic        o_last;

    number_t     numbers_to_send[$];
    column_t     expected_columns[$];
    logic [1:0]  active_phase = '0;
    int          error_count = 0;
    int          cycle_count = 0;

    decimal_number_glyph_renderer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_column_x    (o_column_x),
        .o_column_y    (o_column_y),
        .o_column_bits (o_column_bits),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int sender_idle_pct(input logic [1:0] phase);
        return (phase == 2'd0) ? 18 : (phase == 2'd1) ? 76 : 0;
    endfunction

    function automatic int receiver_stall_pct(input logic [1:0] phase);
        return (phase == 2'd0) ? 76 : (phase == 2'd1) ? 18 : 0;
    endfunction

    // Split into decimal digits, skip leading zeros, queue one write per glyph column.
    task automatic render_columns(input logic [15:0] value, input logic [7:0] sx,
                                  input logic [7:0] sy);
        int      digits[N_DIGITS];
        int      rest;
        int      first;
        int      total;
        int      idx;
        int      pos;
        column_t col;
        rest  = value;
        first = N_DIGITS;
        idx   = 0;
        for (int k = 0; k < N_DIGITS; k++) begin
            digits[k] = rest % 10;
            rest      = rest / 10;
        end
        for (int k = N_DIGITS - 1; k >= 0; k--) begin
            if (digits[k] != 0 && first == N_DIGITS) begin
                first = N_DIGITS - 1 - k;
            end
        end
        total = (N_DIGITS - first) * N_COLUMNS;
        for (int slot = 0; slot < N_DIGITS - first; slot++) begin
            for (int c = 0; c < N_COLUMNS; c++) begin
                pos      = sx + X_STEP * slot + c;
                col.x    = pos[7:0];
                col.y    = sy;
                col.bits = (c < 5) ? DIGIT_FONT[digits[N_DIGITS - 1 - first - slot]][c] : 8'h00;
                col.last = (idx == total - 1);
                expected_columns.push_back(col);
                idx++;
            end
        end
    endtask

    task automatic queue_number(input int value, input int sx, input int sy,
                                input logic [1:0] phase);
        number_t num;
        num.value   = value[15:0];
        num.start_x = sx[7:0];
        num.start_y = sy[7:0];
        num.phase   = phase;
        numbers_to_send.push_back(num);
    endtask

    // Driver: predict on acceptance, then load the next item or idle.
    always @(posedge i_clk) begin : drive_numbers
        number_t num;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                render_columns(i_value, i_start_x, i_start_y);
            end
            if (!i_valid || o_ready) begin
                if (numbers_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct(numbers_to_send[0].phase)) begin
                    num = numbers_to_send.pop_front();
                    i_valid      <= 1'b1;
                    i_value      <= num.value;
                    i_start_x    <= num.start_x;
                    i_start_y    <= num.start_y;
                    active_phase <= num.phase;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted column with the oldest expected one.
    always @(posedge i_clk) begin : check_columns
        column_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_columns.size() == 0) begin
                    $error("unexpected column x=%0d y=%0d bits=%02h last=%0b",
                           o_column_x, o_column_y, o_column_bits, o_last);
                    error_count++;
                end else begin
                    want = expected_columns.pop_front();
                    if (o_column_x !== want.x) begin
                        $error("column_x: expected %0d, got %0d", want.x, o_column_x);
                        error_count++;
                    end
                    if (o_column_y !== want.y) begin
                        $error("column_y: expected %0d, got %0d", want.y, o_column_y);
                        error_count++;
                    end
                    if (o_column_bits !== want.bits) begin
                        $error("column_bits: expected %02h, got %02h", want.bits, o_column_bits);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        error_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_stall_pct(active_phase));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** decimal_number_glyph_renderer_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int ndig;
        int lo;
        int hi;
        int value;
        logic [1:0] phase;
        // edges of the fields, every digit, zeros inside and at the end, x wrap
        queue_number(0,     10,  20,  2'd0);
        queue_number(1,     0,   0,   2'd0);
        queue_number(9,     255, 255, 2'd0);
        queue_number(10,    250, 3,   2'd0);
        queue_number(65535, 255, 0,   2'd0);
        queue_number(65535, 0,   255, 2'd0);
        queue_number(12345, 128, 64,  2'd0);
        queue_number(6789,  230, 170, 2'd0);
        queue_number(10007, 200, 100, 2'd0);
        queue_number(40503, 251, 7,   2'd0);
        queue_number(60000, 1,   1,   2'd0);
        queue_number(100,   85,  42,  2'd0);
        queue_number(1000,  170, 213, 2'd0);
        queue_number(10000, 240, 128, 2'd0);
        queue_number(32768, 127, 254, 2'd0);
        queue_number(0,     255, 255, 2'd0);
        queue_number(99,    253, 15,  2'd0);
        queue_number(54321, 20,  240, 2'd0);
        for (int n = 0; n < RANDOM_NUMS; n++) begin
            phase = (n < RANDOM_NUMS / 3) ? 2'd0 : (n < 2 * RANDOM_NUMS / 3) ? 2'd1 : 2'd2;
            ndig  = $urandom_range(19);
            if (ndig == 0) begin
                value = 0;
            end else if (ndig > 5) begin
                value = $urandom_range(65535);
            end else begin
                lo = 1;
                for (int k = 1; k < ndig; k++) begin
                    lo = lo * 10;
                end
                hi    = (lo * 10 - 1 > 65535) ? 65535 : lo * 10 - 1;
                value = $urandom_range(hi, lo);
            end
            queue_number(value, $urandom_range(255), $urandom_range(255), phase);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold until every item is taken and every column has come back
        while (numbers_to_send.size() != 0 || i_valid || expected_columns.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("** decimal_number_glyph_renderer_unit: PASSED **");
        end else begin
            $display("** decimal_number_glyph_renderer_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: decimal_number_glyph_renderer_unit.f
rtl/dngr_pkg.sv
rtl/decimal_number_glyph_renderer_unit.sv
test/decimal_number_glyph_renderer_unit_tb.sv
